### hdl/mnbd_pkg.sv
// ----------------------------------------------------------------------------
// Mangled-name byte decoder package
// Shared types and constants: the escape phase encoding, the entry that
// carries the results of one item from the front to the back, and the
// default depth of the queue between them.
// ----------------------------------------------------------------------------
package mnbd_pkg;

  // Default number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Largest number of results that one item can cause.
  localparam int MAX_RESULTS = 3;

  // Escape decoding phase.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,  // plain bytes
    PH_ESC   = 2'd1,  // an underscore was seen
    PH_UNI   = 2'd2,  // gathering the four digits of a "_u" escape
    PH_HEX   = 2'd3   // holding the first digit of a "_XY" escape
  } phase_t;

  // The results of one item: up to three bytes, or one empty marker.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]                  count;     // number of results, 1 to 3
    logic                        has_byte;  // 0 for the empty end-of-name marker
    logic                        name_end;  // the item closes the name
  } entry_t;

endpackage

### hdl/mnbd_front.sv
// ----------------------------------------------------------------------------
// Mangled-name byte decoder front end
// Accepts one raw byte per cycle while the result queue is not full, runs the
// escape decoder and the signature and descriptor rewrites, and writes the
// decoded bytes of the item as one entry into the result queue.
// ----------------------------------------------------------------------------
module mnbd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            full,
  input  logic [7:0]      name_byte,
  input  logic            name_last,
  input  logic            raw_name,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            descriptor_mode,
  output logic            q_wr,
  output mnbd_pkg::entry_t q_data
);
  import mnbd_pkg::*;

  // Character codes.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_U    = 8'h75;
  localparam logic [7:0] CH_A          = 8'h41;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_L          = 8'h4C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  // Offsets that map 'A' and 'a' to the digit value ten.
  localparam logic [7:0] UPPER_BASE    = 8'h37;
  localparam logic [7:0] LOWER_BASE    = 8'h57;
  // UTF-8 range limits and lead bytes.
  localparam logic [15:0] UTF8_ONE_MAX = 16'h007F;
  localparam logic [15:0] UTF8_TWO_MAX = 16'h07FF;
  localparam logic [2:0]  LEAD2_TAG    = 3'b110;
  localparam logic [3:0]  LEAD3_TAG    = 4'b1110;
  localparam logic [1:0]  CONT_TAG     = 2'b10;
  localparam logic [1:0]  SPLIT_SIG    = 2'd2;
  localparam logic [1:0]  LAST_DIGIT   = 2'd3;

  // Registers.
  phase_t      phase;
  logic [15:0] hex_gather;
  logic [1:0]  digit_count;
  logic [1:0]  split_count;
  logic        prim_flag;
  logic        leading_a_run;
  logic        desc_mode;

  // Next values.
  phase_t      phase_next;
  logic [15:0] hex_gather_next;
  logic [1:0]  digit_count_next;
  logic [1:0]  split_count_next;
  logic        prim_flag_next;
  logic        leading_a_run_next;

  // Decode intermediates.
  logic        accept;
  logic [7:0]  digit_up;
  logic [7:0]  digit_lo;
  logic [15:0] code_point;
  logic [7:0]  hex_byte;
  logic [1:0]  split_hex;
  logic [MAX_RESULTS-1:0][7:0] dec_bytes;
  logic [1:0]  dec_count;
  logic        lead_hit;

  // The primitive flag after a byte: 'L' clears it, and in the signature
  // section ';', '(' and ')' set it.
  function automatic logic upd_prim(input logic [7:0] ch, input logic [1:0] split,
                                    input logic prim);
    logic res;
    res = prim;
    if (ch == CH_L) begin
      res = 1'b0;
    end else if ((ch == CH_SEMI || ch == CH_LPAREN || ch == CH_RPAREN) &&
                 split == SPLIT_SIG) begin
      res = 1'b1;
    end
    return res;
  endfunction

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  // Hex digit values; out-of-range digits wrap modulo 256.
  assign digit_up   = (name_byte <= CH_NINE) ? name_byte - CH_ZERO : name_byte - UPPER_BASE;
  assign digit_lo   = (name_byte <= CH_NINE) ? name_byte - CH_ZERO : name_byte - LOWER_BASE;
  assign code_point = {hex_gather[11:0], 4'h0} | {8'h00, digit_lo};
  assign hex_byte   = {hex_gather[3:0], 4'h0} + digit_up;
  assign split_hex  = (hex_byte == CH_BAR && split_count != SPLIT_SIG) ?
                      split_count + 2'd1 : split_count;

  // Next escape phase.
  always_comb begin
    phase_next = phase;
    if (!raw_name) begin
      unique case (phase)
        PH_ESC: begin
          if (name_byte == CH_UNDERSCORE) begin
            phase_next = PH_PLAIN;
          end else if (name_byte == CH_LOWER_U) begin
            phase_next = PH_UNI;
          end else begin
            phase_next = PH_HEX;
          end
        end
        PH_UNI: begin
          phase_next = (digit_count == LAST_DIGIT) ? PH_PLAIN : PH_UNI;
        end
        PH_HEX: begin
          phase_next = PH_PLAIN;
        end
        PH_PLAIN: begin
          phase_next = (name_byte == CH_UNDERSCORE) ? PH_ESC : PH_PLAIN;
        end
        default: begin
          phase_next = PH_PLAIN;
        end
      endcase
    end
  end

  // Decoded bytes and the data state that goes with them.
  always_comb begin
    dec_bytes        = '0;
    dec_count        = 2'd0;
    hex_gather_next  = hex_gather;
    digit_count_next = digit_count;
    split_count_next = split_count;
    prim_flag_next   = prim_flag;
    if (raw_name) begin
      dec_bytes[0] = name_byte;
      dec_count    = 2'd1;
    end else begin
      unique case (phase)
        PH_ESC: begin
          if (name_byte == CH_UNDERSCORE) begin
            dec_bytes[0] = CH_UNDERSCORE;
            dec_count    = 2'd1;
          end else if (name_byte == CH_LOWER_U) begin
            hex_gather_next  = '0;
            digit_count_next = 2'd0;
          end else begin
            hex_gather_next = {12'h000, digit_up[3:0]};
          end
        end
        PH_UNI: begin
          hex_gather_next = code_point;
          if (digit_count == LAST_DIGIT) begin
            digit_count_next = 2'd0;
            if (code_point <= UTF8_ONE_MAX) begin
              dec_bytes[0] = code_point[7:0];
              dec_count    = 2'd1;
            end else if (code_point <= UTF8_TWO_MAX) begin
              dec_bytes[0] = {LEAD2_TAG, code_point[10:6]};
              dec_bytes[1] = {CONT_TAG, code_point[5:0]};
              dec_count    = 2'd2;
            end else begin
              dec_bytes[0] = {LEAD3_TAG, code_point[15:12]};
              dec_bytes[1] = {CONT_TAG, code_point[11:6]};
              dec_bytes[2] = {CONT_TAG, code_point[5:0]};
              dec_count    = 2'd3;
            end
          end else begin
            digit_count_next = digit_count + 2'd1;
          end
        end
        PH_HEX: begin
          dec_bytes[0]     = hex_byte;
          dec_count        = 2'd1;
          split_count_next = split_hex;
          prim_flag_next   = upd_prim(hex_byte, split_hex, prim_flag);
        end
        PH_PLAIN: begin
          if (name_byte != CH_UNDERSCORE) begin
            dec_count = 2'd1;
            if (split_count != SPLIT_SIG) begin
              dec_bytes[0] = name_byte;
            end else begin
              prim_flag_next = upd_prim(name_byte, split_count, prim_flag);
              dec_bytes[0]   = (prim_flag_next && name_byte == CH_A) ? CH_LBRACKET : name_byte;
            end
          end
        end
        default: begin
          dec_count = 2'd0;
        end
      endcase
    end
  end

  // Leading 'A' run: only the first byte of an item can be 'A', since the
  // continuation bytes of a longer UTF-8 sequence never are.
  assign lead_hit           = leading_a_run && dec_count != 2'd0 && dec_bytes[0] == CH_A;
  assign leading_a_run_next = (dec_count == 2'd0) ? leading_a_run : lead_hit;

  // Queue entry: the decoded bytes, or an empty marker at a silent name end.
  always_comb begin
    q_data = '0;
    if (dec_count == 2'd0) begin
      q_data.count    = 2'd1;
      q_data.has_byte = 1'b0;
      q_data.name_end = 1'b1;
    end else begin
      q_data.bytes    = dec_bytes;
      q_data.count    = dec_count;
      q_data.has_byte = 1'b1;
      q_data.name_end = name_last;
      if (lead_hit && desc_mode) begin
        q_data.bytes[0] = CH_LBRACKET;
      end
    end
  end

  assign q_wr = accept && (dec_count != 2'd0 || name_last);

  // Decoder state; the last byte of a name returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PLAIN;
      hex_gather    <= '0;
      digit_count   <= '0;
      split_count   <= '0;
      prim_flag     <= 1'b1;
      leading_a_run <= 1'b1;
    end else if (accept) begin
      if (name_last) begin
        phase         <= PH_PLAIN;
        hex_gather    <= '0;
        digit_count   <= '0;
        split_count   <= '0;
        prim_flag     <= 1'b1;
        leading_a_run <= 1'b1;
      end else begin
        phase         <= phase_next;
        hex_gather    <= hex_gather_next;
        digit_count   <= digit_count_next;
        split_count   <= split_count_next;
        prim_flag     <= prim_flag_next;
        leading_a_run <= leading_a_run_next;
      end
    end
  end

  // Descriptor mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      desc_mode <= descriptor_mode;
    end
  end

  // The separator count saturates at two.
  a_split_sat: assert property (@(posedge clk) disable iff (rst)
    split_count != 2'd3)
    else $error("separator count passed its saturation value");

  // A name end leaves the decoder in its reset state.
  a_name_clear: assert property (@(posedge clk) disable iff (rst)
    accept && name_last |=> phase == PH_PLAIN && split_count == 2'd0 &&
                            prim_flag && leading_a_run)
    else $error("decoder state not cleared after the last byte of a name");

  // Digits are counted only while a "_u" escape is being gathered.
  a_digit_phase: assert property (@(posedge clk) disable iff (rst)
    digit_count != 2'd0 |-> phase == PH_UNI)
    else $error("digit count set outside a unicode escape");

endmodule

### hdl/mnbd_queue.sv
// ----------------------------------------------------------------------------
// Mangled-name byte decoder result queue
// A short first-in first-out queue of decoded entries that lets the front
// take new bytes while the back is still sending earlier results.
// ----------------------------------------------------------------------------
module mnbd_queue #(
  parameter int DEPTH = mnbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mnbd_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd,
  output mnbd_pkg::entry_t rd_data,
  output logic             rd_valid
);
  import mnbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue fill count beyond its depth");

  // A write with no read grows the queue by one.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("queue fill count did not follow a write");

  // Every stored entry carries at least one result.
  a_entry_count: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> rd_data.count != 2'd0)
    else $error("queue entry with no results");

endmodule

### hdl/mnbd_back.sv
// ----------------------------------------------------------------------------
// Mangled-name byte decoder back end
// Takes entries from the result queue and sends their results one at a time
// through an output register, marking the last result of each item and of
// each name.
// ----------------------------------------------------------------------------
module mnbd_back (
  input  logic             clk,
  input  logic             rst,
  input  mnbd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             head_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             run_last,
  output logic             name_end
);
  import mnbd_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       pop_fire;
  logic       load;
  logic       final_one;
  logic [7:0] sel_byte;

  assign empty     = !out_valid;
  assign pop_fire  = pop && out_valid;
  assign load      = head_valid && (!out_valid || pop_fire);
  assign final_one = (idx + 2'd1 == head.count);
  assign head_pop  = load && final_one;

  // Byte of the head entry that goes out next.
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[2];
      default: sel_byte = '0;
    endcase
  end

  // Position within the head entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= final_one ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= sel_byte;
      byte_valid <= head.has_byte;
      run_last   <= final_one;
      name_end   <= final_one && head.name_end;
    end
  end

endmodule

### hdl/mangled_name_byte_decoder.sv
// ----------------------------------------------------------------------------
// Mangled-name byte decoder
// Top level: front decoder, result queue and result serializer.
// ----------------------------------------------------------------------------
// The block takes one byte of a mangled name per cycle on push/full and
// delivers the decoded bytes on empty/pop, one result per cycle while pop is
// held. An item is accepted in every cycle in which the result queue has room
// (QUEUE_DEPTH entries, at most one entry per item); the item is decoded in
// the cycle it is accepted, and its results pass through a queue slot and the
// output register before they can be taken. An item causes zero to three
// results; the single result port sets the sustained rate at one result per
// cycle, so a three-byte "_u" escape holds the output while the queue keeps
// absorbing input. descriptor_mode is written through cfg_valid/cfg_ready
// (always ready) and should only change while no name is in flight.
module mangled_name_byte_decoder #(
  parameter int QUEUE_DEPTH = mnbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] name_byte,
  input  logic       name_last,
  input  logic       raw_name,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       name_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       descriptor_mode
);
  import mnbd_pkg::*;

  logic   q_wr;
  entry_t q_wr_data;
  logic   q_rd;
  entry_t q_head;
  logic   q_valid;

  // Byte decoder.
  mnbd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .name_byte       (name_byte),
    .name_last       (name_last),
    .raw_name        (raw_name),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .descriptor_mode (descriptor_mode),
    .q_wr            (q_wr),
    .q_data          (q_wr_data)
  );

  // Queue of decoded entries.
  mnbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_data  (q_wr_data),
    .full     (full),
    .rd       (q_rd),
    .rd_data  (q_head),
    .rd_valid (q_valid)
  );

  // Result serializer.
  mnbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .head_pop   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .name_end   (name_end)
  );

endmodule
